/* sv/prba_pkg.sv */
// Shared types and codes for the page run bitmap allocator.
// Depends on nothing; every other file but prba_ram.sv refers to it by scoped names.
package prba_pkg;

  // Page numbers reachable through the 9-bit page count live below 512;
  // ten bits also hold base_page + page_count without wrapping.
  localparam int PN_W = 10;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_NORUN   = 2'd2;
  localparam logic [1:0] STAT_BAD     = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [8:0] page_count;
    logic [7:0] base_page;
  } in_item_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] status;
    logic [7:0] run_start;
    logic [8:0] free_pages;
  } out_item_t;

  // Request class as decided by the front end.
  typedef enum logic [1:0] {
    KIND_BAD     = 2'd0,
    KIND_NOSPACE = 2'd1,
    KIND_ALLOC   = 2'd2,
    KIND_FREE    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [8:0] page_count;
    logic [7:0] base_page;
  } cmd_t;

  // Status the back end reports to the front end.
  typedef struct packed {
    logic       clearing;
    logic       done;
    logic [8:0] free_count;
    logic [8:0] pages;
  } back_stat_t;

endpackage

/* sv/page_run_bitmap_allocator.sv */
// Top level of the first-fit page run allocator.
// Depends on prba_pkg; instantiates prba_front, prba_queue and prba_back.
//
// Usage. A request (allocate or free a run of pages) is transferred on the
// in_ side at a clock edge where start is high and busy is low. Exactly one
// result follows per request: out_valid is high for one cycle with out_data,
// and the receiver takes it in that cycle; it has no way to hold it off.
// The pool size is written through the cfg_ channel (cfg_ready is always
// high); each write re-initializes the pool, marking every page free.
//
// Flow. Rejected requests (zero count, too few free pages, free range past
// the pool) give their result without walking the map. A free rewrites each
// map word its run covers. An allocate scans the map one 16-page word per
// cycle until the first fitting run ends, then rewrites the words that run
// covers. The map RAM port handles one word per cycle. busy stays high from
// the transfer until the result strobe, so one request is in flight at a time.
//
// Reset and configuration. After reset, and after every configuration write,
// a clearing pass writes zero to every map word, one per cycle; busy is high
// meanwhile.
module page_run_bitmap_allocator #(
  parameter int MAX_PAGES = 256
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                start,
  output logic                busy,
  input  prba_pkg::in_item_t  in_data,

  output logic                out_valid,
  output prba_pkg::out_item_t out_data,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [8:0]          cfg_data
);

  prba_pkg::back_stat_t stat;
  prba_pkg::cmd_t       push_cmd;
  prba_pkg::cmd_t       head_cmd;
  logic                 push;
  logic                 pop;
  logic                 not_empty;
  logic                 cfg_we;

  // The register can always be taken; the back end restarts its clear on it.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Front end: handshake and classification against the current pool state.
  prba_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .stat     (stat),
    .busy     (busy),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Short command queue decoupling classification from map work.
  prba_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .not_empty (not_empty),
    .head_cmd  (head_cmd)
  );

  // Back end: map RAM, free count, scan and mark sequencer, result register.
  prba_back #(
    .MAX_PAGES (MAX_PAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_valid   (not_empty),
    .q_cmd     (head_cmd),
    .q_pop     (pop),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* sv/prba_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module prba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/prba_queue.sv */
// Two-entry command queue between the front end and the back end.
// Depends on prba_pkg for the command type.
module prba_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  prba_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output logic            not_empty,
  output prba_pkg::cmd_t  head_cmd
);

  prba_pkg::cmd_t entry_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign not_empty = (cnt_r != 2'd0);
  assign head_cmd  = entry_r[rp_r];
  assign do_push   = push && (cnt_r != 2'd2);
  assign do_pop    = pop && not_empty;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wp_r] <= push_cmd;
    end
  end

endmodule

/* sv/prba_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on prba_pkg for the item, command and status types.
module prba_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  prba_pkg::in_item_t   in_data,
  input  prba_pkg::back_stat_t stat,
  output logic                 busy,
  output logic                 push,
  output prba_pkg::cmd_t       push_cmd
);

  logic                  inflight_r, inflight_nxt;
  logic                  accept;
  logic [prba_pkg::PN_W-1:0] range_end;
  prba_pkg::kind_t       kind;

  assign busy   = inflight_r || stat.clearing;
  assign accept = start && !busy;
  assign push   = accept;

  assign range_end = {2'b00, in_data.base_page} + {1'b0, in_data.page_count};

  // Rejections that need no map walk are settled here, so the back end only walks the map when needed.
  always_comb begin
    if (in_data.page_count == 9'd0) begin
      kind = prba_pkg::KIND_BAD;
    end else if (in_data.operation == prba_pkg::OP_ALLOC) begin
      kind = (in_data.page_count > stat.free_count) ? prba_pkg::KIND_NOSPACE
                                                    : prba_pkg::KIND_ALLOC;
    end else begin
      kind = (range_end > {1'b0, stat.pages}) ? prba_pkg::KIND_BAD
                                               : prba_pkg::KIND_FREE;
    end
  end

  always_comb begin
    push_cmd.kind       = kind;
    push_cmd.page_count = in_data.page_count;
    push_cmd.base_page  = in_data.base_page;
  end

  always_comb begin
    inflight_nxt = inflight_r;
    if (stat.done) begin
      inflight_nxt = 1'b0;
    end
    if (accept) begin
      inflight_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 1'b0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

endmodule

/* sv/prba_back.sv */
// Back end: owns the page map RAM and free count, runs scans, marks and clears.
// Depends on prba_pkg and instantiates prba_ram.
module prba_back #(
  parameter int MAX_PAGES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [8:0]           cfg_data,
  input  logic                 q_valid,
  input  prba_pkg::cmd_t       q_cmd,
  output logic                 q_pop,
  output prba_pkg::back_stat_t stat,
  output logic                 out_valid,
  output prba_pkg::out_item_t  out_data
);

  localparam int PN_W      = prba_pkg::PN_W;
  localparam int WB        = (MAX_PAGES >= 16) ? 4 : 3;
  localparam int W         = 1 << WB;
  localparam int NWORDS    = (MAX_PAGES + W - 1) / W;
  localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int WC_W      = PN_W - WB;
  localparam int MAX_EFF   = (MAX_PAGES > 511) ? 511 : MAX_PAGES;
  localparam int RST_PAGES = (MAX_PAGES < 256) ? MAX_PAGES : 256;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_MARK  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [WC_W-1:0]     rw_r, rw_nxt;
  logic [PN_W-1:0]     run_r, run_nxt;
  logic [PN_W-1:0]     lo_r, lo_nxt;
  logic [PN_W-1:0]     hi_r, hi_nxt;
  logic                set_r, set_nxt;
  logic [8:0]          n_r, n_nxt;
  logic [8:0]          free_r, free_nxt;
  logic [8:0]          pages_r, pages_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic                out_valid_r, out_valid_nxt;
  prba_pkg::out_item_t out_r, out_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [W-1:0]        ram_wdata, ram_rdata;

  logic [PN_W-1:0]     page_of [W];
  logic [W-1:0]        used_w, hit_w, mask_w;
  logic [W-1:0]        seen_used;
  logic [WB-1:0]       last_used [W];
  logic [PN_W-1:0]     run_j [W];
  logic                hit_any;
  logic [WB-1:0]       hit_pos;
  logic [PN_W-1:0]     end_pg, first_pg, last_pg, free_lo, free_hi;
  logic [PN_W-1:0]     free_sum;
  logic [8:0]          eff_pages;

  prba_ram #(
    .WIDTH (W),
    .DEPTH (NWORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign eff_pages = (cfg_data > 9'(MAX_EFF)) ? 9'(MAX_EFF) : cfg_data;
  assign last_pg   = {1'b0, pages_r} - PN_W'(1);
  assign free_lo   = {2'b00, q_cmd.base_page};
  assign free_hi   = free_lo + {1'b0, q_cmd.page_count} - PN_W'(1);
  assign free_sum  = {1'b0, free_r} + {1'b0, n_r};

  // Per-page view of the word that the RAM returns this cycle.
  always_comb begin
    for (int j = 0; j < W; j++) begin
      page_of[j] = {rw_r, WB'(j)};
      used_w[j]  = ram_rdata[j] || (page_of[j] >= {1'b0, pages_r});
      mask_w[j]  = (page_of[j] >= lo_r) && (page_of[j] <= hi_r);
    end
  end

  // Free-run length ending at each bit, carried in from earlier words.
  always_comb begin
    for (int j = 0; j < W; j++) begin
      seen_used[j] = 1'b0;
      last_used[j] = '0;
      for (int i = 0; i <= j; i++) begin
        if (used_w[i]) begin
          seen_used[j] = 1'b1;
          last_used[j] = WB'(i);
        end
      end
      if (seen_used[j]) begin
        run_j[j] = PN_W'(j) - PN_W'(last_used[j]);
      end else begin
        run_j[j] = run_r + PN_W'(j + 1);
      end
      hit_w[j] = !used_w[j] && (run_j[j] >= {1'b0, n_r});
    end
  end

  always_comb begin
    hit_any = |hit_w;
    hit_pos = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (hit_w[j]) begin
        hit_pos = WB'(j);
      end
    end
  end

  assign end_pg   = {rw_r, hit_pos};
  assign first_pg = end_pg + PN_W'(1) - {1'b0, n_r};

  always_comb begin
    state_nxt     = state_r;
    rw_nxt        = rw_r;
    run_nxt       = run_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    set_nxt       = set_r;
    n_nxt         = n_r;
    free_nxt      = free_r;
    pages_nxt     = pages_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = AW'(rw_r);
    ram_wdata     = '0;
    ram_raddr     = AW'(rw_r);

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(NWORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          n_nxt = q_cmd.page_count;
          unique case (q_cmd.kind)
            prba_pkg::KIND_BAD: begin
              out_valid_nxt      = 1'b1;
              out_nxt.ok         = 1'b0;
              out_nxt.status     = prba_pkg::STAT_BAD;
              out_nxt.run_start  = '0;
              out_nxt.free_pages = free_r;
            end
            prba_pkg::KIND_NOSPACE: begin
              out_valid_nxt      = 1'b1;
              out_nxt.ok         = 1'b0;
              out_nxt.status     = prba_pkg::STAT_NOSPACE;
              out_nxt.run_start  = '0;
              out_nxt.free_pages = free_r;
            end
            prba_pkg::KIND_ALLOC: begin
              run_nxt   = '0;
              rw_nxt    = '0;
              ram_raddr = '0;
              set_nxt   = 1'b1;
              state_nxt = S_SCAN;
            end
            prba_pkg::KIND_FREE: begin
              lo_nxt    = free_lo;
              hi_nxt    = free_hi;
              rw_nxt    = free_lo[PN_W-1:WB];
              ram_raddr = AW'(free_lo[PN_W-1:WB]);
              set_nxt   = 1'b0;
              state_nxt = S_MARK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit_any) begin
          lo_nxt    = first_pg;
          hi_nxt    = end_pg;
          rw_nxt    = first_pg[PN_W-1:WB];
          ram_raddr = AW'(first_pg[PN_W-1:WB]);
          state_nxt = S_MARK;
        end else if (rw_r == last_pg[PN_W-1:WB]) begin
          out_valid_nxt      = 1'b1;
          out_nxt.ok         = 1'b0;
          out_nxt.status     = prba_pkg::STAT_NORUN;
          out_nxt.run_start  = '0;
          out_nxt.free_pages = free_r;
          state_nxt          = S_IDLE;
        end else begin
          rw_nxt    = rw_r + WC_W'(1);
          ram_raddr = AW'(rw_r + WC_W'(1));
          run_nxt   = run_j[W-1];
        end
      end
      S_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = set_r ? (ram_rdata | mask_w) : (ram_rdata & ~mask_w);
        if (rw_r == hi_r[PN_W-1:WB]) begin
          if (set_r) begin
            free_nxt          = free_r - n_r;
            out_nxt.run_start = lo_r[7:0];
          end else begin
            free_nxt          = (free_sum > {1'b0, pages_r}) ? pages_r : free_sum[8:0];
            out_nxt.run_start = '0;
          end
          out_valid_nxt      = 1'b1;
          out_nxt.ok         = 1'b1;
          out_nxt.status     = prba_pkg::STAT_OK;
          out_nxt.free_pages = free_nxt;
          state_nxt          = S_IDLE;
        end else begin
          rw_nxt    = rw_r + WC_W'(1);
          ram_raddr = AW'(rw_r + WC_W'(1));
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A register write re-initializes the pool and restarts the clearing pass.
    if (cfg_we) begin
      pages_nxt = eff_pages;
      free_nxt  = eff_pages;
      clr_nxt   = '0;
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pages_r     <= 9'(RST_PAGES);
      free_r      <= 9'(RST_PAGES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pages_r     <= pages_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rw_r  <= rw_nxt;
    run_r <= run_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    set_r <= set_nxt;
    n_r   <= n_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    stat.clearing   = (state_r == S_CLEAR) || cfg_we;
    stat.done       = out_valid_nxt;
    stat.free_count = free_r;
    stat.pages      = pages_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for page_run_bitmap_allocator, the first-fit page run allocator.
// Depends on prba_pkg for the request and result structs and the status and operation codes.
module testbench;

  localparam int POOL_MAX = 256;
  // The longest correct quiet stretch is a driver idle gap, a clearing pass and an allocate
  // scan; the watchdog allows many times that.
  localparam int HANG_LIMIT = 2000;
  localparam int RAND_PER_PHASE = 94;
  // Every request yields exactly one result, so once the last result has come the block is idle.
  // The tail only gives a stray extra strobe the chance to show up.
  localparam int TAIL_CYCLES = 50;
  localparam int IN_W = $bits(prba_pkg::in_item_t);

  // A pending request together with the idle cycles the driver waits before offering it.
  typedef struct {
    prba_pkg::in_item_t req;
    int                 gap;
  } slot_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  prba_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  prba_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [8:0]          cfg_data = '0;

  page_run_bitmap_allocator #(.MAX_PAGES(POOL_MAX)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the allocator: the occupancy bitmap, the free count and the pool size that
  // is actually in effect, with the register value limited to POOL_MAX.
  bit map_bits [POOL_MAX];
  int free_left;
  int pool_pages;

  slot_t               request_q [$];  // requests waiting for the driver
  prba_pkg::out_item_t outcome_q [$];  // results owed by the block, oldest first

  int  n_queued = 0;
  int  n_taken = 0;
  int  n_results = 0;
  int  n_cfg = 0;
  int  err_count = 0;
  int  idle_cycles = 0;
  int  calm_left = 0;
  int  status_tally [4] = '{0, 0, 0, 0};

  // Every configuration write rebuilds the pool: all pages free, the count set to the pool size.
  function automatic void pool_reset(int value);
    pool_pages = (value > POOL_MAX) ? POOL_MAX : value;
    foreach (map_bits[i]) map_bits[i] = 1'b0;
    free_left = pool_pages;
  endfunction

  // Applies one request to the shadow pool and returns the result the block must give for it.
  // A zero count is always rejected. An allocate that asks for more than the free count is
  // short of pages. Otherwise the lowest run of free pages that is long enough is taken; if
  // there is none, nothing changes. A free must lie inside the pool. It clears the bits, even
  // ones already clear, and the count saturates at the pool size.
  function automatic prba_pkg::out_item_t first_fit_outcome(prba_pkg::in_item_t req);
    prba_pkg::out_item_t res;
    int n, sp, run, first, i;
    bit found;
    res = '0;
    n = int'(req.page_count);
    sp = int'(req.base_page);
    run = 0;
    first = 0;
    found = 1'b0;
    if (n == 0) begin
      res.status = prba_pkg::STAT_BAD;
    end else if (req.operation == prba_pkg::OP_ALLOC) begin
      if (n > free_left) begin
        res.status = prba_pkg::STAT_NOSPACE;
      end else begin
        for (i = 0; i < pool_pages && !found; i++) begin
          if (!map_bits[i]) begin
            run++;
            if (run == n) begin
              first = i + 1 - n;
              found = 1'b1;
            end
          end else begin
            run = 0;
          end
        end
        if (!found) begin
          res.status = prba_pkg::STAT_NORUN;
        end else begin
          for (i = first; i < first + n; i++) map_bits[i] = 1'b1;
          free_left -= n;
          res.status = prba_pkg::STAT_OK;
          res.run_start = 8'(first);
        end
      end
    end else if (sp + n > pool_pages) begin
      res.status = prba_pkg::STAT_BAD;
    end else begin
      for (i = sp; i < sp + n; i++) map_bits[i] = 1'b0;
      free_left += n;
      if (free_left > pool_pages) free_left = pool_pages;
      res.status = prba_pkg::STAT_OK;
    end
    res.ok = (res.status == prba_pkg::STAT_OK);
    res.free_pages = 9'(free_left);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [8:0] got, logic [8:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                n_results, name, got, want));
  endtask

  // Queues one request. The idle gap in front of it is random, but now and then a stretch of
  // back-to-back requests is laid down so that the block also runs at full rate.
  task automatic add_request(logic op, int n, int sp);
    slot_t s;
    s.req.operation = op;
    s.req.page_count = 9'(n);
    s.req.base_page = 8'(sp);
    if (calm_left > 0) begin
      calm_left--;
      s.gap = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(5, 30);
      s.gap = 0;
    end else begin
      s.gap = $urandom_range(0, 11);
    end
    request_q.push_back(s);
    n_queued++;
  endtask

  // Random traffic for a pool of eff pages. Most of it is small allocations and frees that lie
  // inside the pool. Together they fragment the map, so first fit has real work to do and both
  // kinds of allocation failure turn up. The rest is noise: zero and oversized counts, and
  // ranges that run past the pool. base_page is random on allocates, where it must be ignored.
  task automatic queue_random(int eff, int count);
    int pick, lim, n, sp;
    logic op;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      sp = $urandom_range(0, 255);
      if (pick < 52) begin
        op = prba_pkg::OP_ALLOC;
        lim = (eff < 12) ? eff : 12;
        if (lim < 1) lim = 1;
        if (pick < 40) n = $urandom_range(1, lim);
        else if (pick < 48) n = $urandom_range(1, (eff < 1) ? 1 : eff);
        else n = $urandom_range(0, 511);
      end else if (pick < 92 && eff > 0) begin
        op = prba_pkg::OP_FREE;
        sp = $urandom_range(0, eff - 1);
        lim = eff - sp;
        if (pick < 86 && lim > 16) lim = 16;
        n = $urandom_range(1, lim);
      end else begin
        op = $urandom_range(0, 1) ? prba_pkg::OP_FREE : prba_pkg::OP_ALLOC;
        n = $urandom_range(0, 511);
      end
      add_request(op, n, sp);
    end
  endtask

  // Idle means every queued request has been transferred and its result has arrived.
  task automatic wait_drained();
    do @(negedge clk); while (n_taken != n_queued || outcome_q.size() != 0);
  endtask

  // Driver: changes the request port at falling edges. It holds start and the request until a
  // transfer is seen, then moves on to the next request or to that request's idle gap. While
  // start is low the request bus carries random junk that the block must not take. A request
  // is still pending while fewer requests have been transferred than handed out here.
  slot_t cur;
  int    gap_left = 0;
  int    n_popped = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else begin
      if (n_popped == n_taken && request_q.size() != 0) begin
        cur = request_q.pop_front();
        gap_left = cur.gap;
        n_popped++;
      end
      if (n_popped != n_taken && gap_left == 0) begin
        start <= 1'b1;
        in_data <= cur.req;
      end else begin
        if (n_popped != n_taken) gap_left--;
        start <= 1'b0;
        in_data <= prba_pkg::in_item_t'(IN_W'($urandom));
      end
    end
  end

  // Monitor: samples at rising edges. A result is checked before a request transfer in the same
  // cycle is predicted, since that result belongs to an earlier request. A configuration
  // transfer rebuilds the shadow pool at the same edge as the block's. The watchdog counts
  // cycles in which nothing moved on any channel.
  always @(posedge clk) begin : monitor
    prba_pkg::out_item_t want;
    bit moved;
    moved = 0;
    if (!rst_n) begin
      pool_reset(POOL_MAX);
      idle_cycles = 0;
    end else begin
      if (out_valid) begin
        moved = 1;
        n_results++;
        if (outcome_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    n_results));
        end else begin
          want = outcome_q.pop_front();
          check_field("ok", 9'(out_data.ok), 9'(want.ok));
          check_field("status", 9'(out_data.status), 9'(want.status));
          check_field("run_start", 9'(out_data.run_start), 9'(want.run_start));
          check_field("free_pages", out_data.free_pages, want.free_pages);
        end
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1;
        n_cfg++;
        pool_reset(int'(cfg_data));
      end
      if (start && !busy) begin
        moved = 1;
        want = first_fit_outcome(in_data);
        outcome_q.push_back(want);
        status_tally[want.status]++;
        n_taken++;
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= HANG_LIMIT) begin
          $display("Watchdog: nothing transferred for %0d cycles, %0d results still owed.",
                   HANG_LIMIT, outcome_q.size());
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // Sequence of the run: a directed pass on the reset-size pool, then one random phase per pool
  // size. Pool sizes are changed only with the block idle. Every request yields a result, so
  // once the last one is in, no work is left that a write could disturb.
  initial begin : stimulus
    int size_list [$];
    int eff;
    size_list = '{1, 17, 256, 0, 64, 511, 200, 5, 256, 300, 2};
    size_list.push_back($urandom_range(1, 511));

    // Directed pass on the 256-page pool the block comes out of reset with.
    add_request(prba_pkg::OP_ALLOC, 0, 0);      // zero count is rejected
    add_request(prba_pkg::OP_FREE, 0, 255);     // zero count on a free too
    add_request(prba_pkg::OP_ALLOC, 1, 0);      // first page of an empty pool
    add_request(prba_pkg::OP_ALLOC, 256, 0);    // one more than is free
    add_request(prba_pkg::OP_ALLOC, 511, 255);  // widest count
    add_request(prba_pkg::OP_ALLOC, 255, 0);    // takes the rest, pool now full
    add_request(prba_pkg::OP_ALLOC, 1, 0);      // nothing left
    add_request(prba_pkg::OP_FREE, 1, 255);     // last page
    add_request(prba_pkg::OP_FREE, 2, 255);     // range runs off the end
    add_request(prba_pkg::OP_FREE, 256, 0);     // frees everything, count saturates
    add_request(prba_pkg::OP_ALLOC, 256, 0);    // whole pool in one run
    add_request(prba_pkg::OP_FREE, 5, 10);
    add_request(prba_pkg::OP_FREE, 10, 100);
    add_request(prba_pkg::OP_ALLOC, 12, 0);     // enough pages, but no run long enough
    add_request(prba_pkg::OP_ALLOC, 10, 0);     // exact fit in the second hole
    add_request(prba_pkg::OP_FREE, 5, 10);      // double free still adds to the count
    add_request(prba_pkg::OP_FREE, 511, 0);     // far past the end
    add_request(prba_pkg::OP_FREE, 128, 128);
    add_request(prba_pkg::OP_ALLOC, 3, 255);    // base page ignored, first fit at page 10
    add_request(prba_pkg::OP_FREE, 256, 0);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    queue_random(POOL_MAX, RAND_PER_PHASE);
    wait_drained();

    foreach (size_list[k]) begin
      eff = (size_list[k] > POOL_MAX) ? POOL_MAX : size_list[k];
      cfg_valid <= 1'b1;
      cfg_data <= 9'(size_list[k]);
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
      queue_random(eff, RAND_PER_PHASE);
      @(negedge clk);
      cfg_valid <= 1'b0;
      cfg_data <= 9'($urandom);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d requests through %0d pool sizes after the reset pool of %0d pages.",
             n_taken, n_cfg, POOL_MAX);
    $display("Results: %0d succeeded, %0d short of pages, %0d with no run, %0d rejected.",
             status_tally[prba_pkg::STAT_OK], status_tally[prba_pkg::STAT_NOSPACE],
             status_tally[prba_pkg::STAT_NORUN], status_tally[prba_pkg::STAT_BAD]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
